@@ hw/rtl/tbah_pkg.sv @@
// Shared constants and types for the time bucket average history block.
`timescale 1ns / 1ps

package tbah_pkg;

  localparam int Depth = 512;
  localparam int AddrW = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);
  localparam logic [16:0] BucketReset = 17'd300;
  localparam logic [16:0] CountMax = 17'd131071;

  // Request kinds
  localparam logic ReqSample = 1'b0;
  localparam logic ReqRead = 1'b1;

  // Divider width: widest dividend (gas sum, 41 bits)
  localparam int DivW = 41;

  typedef struct packed {
    logic start;
    logic [DivW-1:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DivW-1:0] quotient;
    logic [16:0] remainder;
  } div_rsp_t;

endpackage

@@ hw/rtl/tbah_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tbah_div
  import tbah_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int StepW = $clog2(DivW + 1);

  logic [DivW-1:0] quo;
  logic [17:0] rem;
  logic [16:0] dsr;
  logic [StepW-1:0] steps;
  logic busy;
  logic done;
  logic [17:0] trial;
  logic [18:0] diff;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem[16:0], quo[DivW-1]};
    diff = {1'b0, trial} - {2'b00, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo <= req.dividend;
        dsr <= req.divisor;
        rem <= '0;
        steps <= StepW'(DivW);
      end else if (busy) begin
        if (diff[18]) begin
          rem <= trial;
          quo <= {quo[DivW-2:0], 1'b0};
        end else begin
          rem <= diff[17:0];
          quo <= {quo[DivW-2:0], 1'b1};
        end
        steps <= steps - 1'b1;
        if (steps == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;
  assign rsp.remainder = rem[16:0];

endmodule

@@ hw/rtl/time_bucket_average_history_core.sv @@
// Top level: bucketed averaging of sensor samples into a history ring.
//
//  channel  | valid/ready          | payload
//  ---------+----------------------+----------------------------------
//  s_axis   | s_axis_tvalid/tready | tdata: request fields, tuser=req_type
//  m_axis   | m_axis_tvalid/tready | tdata: result fields
//  config   | bucket_seconds_we    | bucket_seconds_wdata (17 bits)
//
// A read waits on the registered ring memory read. A sample with sensor_ok
// set and a nonzero bucket length runs the bucket modulo, then a bucket close
// runs four divisions, one per channel average, all on the one shared
// bit-serial divider; other samples are ignored. Reset (rst, synchronous)
// clears control state; the ring contents stay undefined until written.
// The input is not ready while an item is in work or a result is unclaimed.
`timescale 1ns / 1ps

module time_bucket_average_history_core
  import tbah_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         bucket_seconds_we,
  input  logic [16:0]  bucket_seconds_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: time_sec, sensor_ok, temperature_in, humidity_in,
  // pressure_in, gas_in, read_index (112 bits)
  input  logic [111:0] s_axis_tdata,
  // tuser: req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: point_valid, point_time, temperature_out, humidity_out,
  // pressure_out, gas_out, stored_count, revision_out, pushed, zero fill
  output logic [151:0] m_axis_tdata
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRead  = 4'd1;
  localparam logic [3:0] StRdWt  = 4'd2;
  localparam logic [3:0] StMod   = 4'd3;
  localparam logic [3:0] StModWt = 4'd4;
  localparam logic [3:0] StDecide= 4'd5;
  localparam logic [3:0] StDiv   = 4'd6;
  localparam logic [3:0] StDivWt = 4'd7;
  localparam logic [3:0] StPush  = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  logic [3:0] state;
  logic [16:0] bucket_seconds;

  // Captured item
  logic        req;
  logic [31:0] now;
  logic        ok;
  logic signed [14:0] te;
  logic [13:0] hu;
  logic [16:0] pr;
  logic [23:0] ga;
  logic [8:0]  ri;

  // Bucket state
  logic        bucket_active;
  logic [31:0] current_bucket_start;
  logic [16:0] samples_in_bucket;
  logic signed [31:0] temperature_sum;
  logic [30:0] humidity_sum;
  logic [33:0] pressure_sum;
  logic [40:0] gas_sum;
  logic [31:0] start;

  // Ring
  logic [AddrW-1:0]  write_head;
  logic [CountW-1:0] point_count;
  logic [31:0] revision;
  logic [101:0] ring [Depth];
  logic [101:0] rd_data;
  logic [101:0] push_data;
  logic [AddrW-1:0] rd_addr;

  // Averages
  logic [1:0]  chan;
  logic        tneg;
  logic signed [14:0] avg_t;
  logic [13:0] avg_h;
  logic [16:0] avg_p;
  logic [23:0] avg_g;
  logic        pushed;
  logic        rd_valid;

  div_req_t dreq;
  div_rsp_t drsp;

  tbah_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Read address counted from the oldest entry
  assign rd_addr = AddrW'(write_head - AddrW'(point_count) + ri);

  // Divider operands per phase
  logic [31:0] tabs;
  assign tabs = temperature_sum[31] ? -temperature_sum : temperature_sum;
  always_comb begin
    dreq.start = 1'b0;
    dreq.divisor = samples_in_bucket;
    dreq.dividend = {9'd0, tabs};
    if (state == StMod) begin
      dreq.start = 1'b1;
      dreq.divisor = bucket_seconds;
      dreq.dividend = {9'd0, now};
    end else if (state == StDiv) begin
      dreq.start = 1'b1;
      case (chan)
        2'd0: dreq.dividend = {9'd0, tabs};
        2'd1: dreq.dividend = {10'd0, humidity_sum};
        2'd2: dreq.dividend = {7'd0, pressure_sum};
        default: dreq.dividend = gas_sum;
      endcase
    end
  end

  assign s_axis_tready = (state == StIdle);

  // Ring memory
  always_ff @(posedge clk) begin
    if (state == StPush) ring[write_head] <= push_data;
    rd_data <= ring[rd_addr];
  end

  always_comb begin
    if (!bucket_active)
      push_data = {now, te, hu, pr, ga};
    else
      push_data = {current_bucket_start, avg_t, avg_h, avg_p, avg_g};
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      bucket_seconds <= BucketReset;
      bucket_active <= 1'b0;
      samples_in_bucket <= '0;
      write_head <= '0;
      point_count <= '0;
      revision <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (bucket_seconds_we) bucket_seconds <= bucket_seconds_wdata;
      case (state)
        StIdle: begin
          if (s_axis_tvalid) begin
            req <= s_axis_tuser;
            now <= s_axis_tdata[31:0];
            ok <= s_axis_tdata[32];
            te <= s_axis_tdata[47:33];
            hu <= s_axis_tdata[61:48];
            pr <= s_axis_tdata[78:62];
            ga <= s_axis_tdata[102:79];
            ri <= s_axis_tdata[111:103];
            pushed <= 1'b0;
            rd_valid <= 1'b0;
            state <= StRead;
          end
        end
        StRead: begin
          if (req == ReqRead) begin
            rd_valid <= (CountW'(ri) < point_count);
            state <= StRdWt;
          end else if (ok && bucket_seconds != 17'd0) begin
            state <= StMod;
          end else begin
            state <= StOut;
          end
        end
        StRdWt: state <= StOut;
        StMod: state <= StModWt;
        StModWt: begin
          if (drsp.done) begin
            start <= now - {15'd0, drsp.remainder};
            state <= StDecide;
          end
        end
        StDecide: begin
          if (!bucket_active) begin
            state <= StPush;
          end else if (start != current_bucket_start) begin
            chan <= 2'd0;
            tneg <= temperature_sum[31];
            state <= StDiv;
          end else begin
            if (samples_in_bucket < CountMax) begin
              samples_in_bucket <= samples_in_bucket + 1'b1;
              temperature_sum <= temperature_sum + 32'(te);
              humidity_sum <= humidity_sum + 31'(hu);
              pressure_sum <= pressure_sum + 34'(pr);
              gas_sum <= gas_sum + 41'(ga);
            end
            state <= StOut;
          end
        end
        StDiv: state <= StDivWt;
        StDivWt: begin
          if (drsp.done) begin
            case (chan)
              2'd0: avg_t <= tneg ? -drsp.quotient[14:0] : drsp.quotient[14:0];
              2'd1: avg_h <= drsp.quotient[13:0];
              2'd2: avg_p <= drsp.quotient[16:0];
              default: avg_g <= drsp.quotient[23:0];
            endcase
            chan <= chan + 1'b1;
            state <= (chan == 2'd3) ? StPush : StDiv;
          end
        end
        StPush: begin
          write_head <= AddrW'(write_head + 1'b1);
          if (point_count < CountW'(Depth)) point_count <= point_count + 1'b1;
          revision <= revision + 1'b1;
          pushed <= 1'b1;
          // Open the new bucket with this sample
          bucket_active <= 1'b1;
          current_bucket_start <= start;
          samples_in_bucket <= 17'd1;
          temperature_sum <= 32'(te);
          humidity_sum <= 31'(hu);
          pressure_sum <= 34'(pr);
          gas_sum <= 41'(ga);
          state <= StOut;
        end
        StOut: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // Result packing
  logic [101:0] pt;
  assign pt = rd_valid ? rd_data : '0;
  assign m_axis_tdata = {6'd0, pushed, revision, point_count,
                         pt[23:0], pt[40:24], pt[54:41], pt[69:55], pt[101:70],
                         rd_valid};

endmodule
